FILE: rtl/core/pkchl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the pair lookup core
`default_nettype none

package pkchl_pkg;

    localparam int HASH_BUCKETS_DEF = 1024;
    localparam int POOL_ENTRIES_DEF = 512;
    localparam int TOKEN_W          = 32;
    localparam int HASH_SHIFT       = 4;

    typedef enum logic [1:0] {
        ST_LOOKUP   = 2'd0,
        ST_INS_OK   = 2'd1,
        ST_INS_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_MISS     = 2'd0,
        RES_HIT      = 2'd1,
        RES_INS_OK   = 2'd2,
        RES_INS_FULL = 2'd3
    } t_res;

    typedef struct packed {
        logic clr_wr;
        logic in_take;
        logic bkt_rd;
        logic bkt_src_in;
        logic ins_wr;
        logic ent_rd;
        logic ent_src_link;
        logic res_load;
        t_res res_kind;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic bkt_valid;
        logic pool_full;
        logic key_match;
        logic link_valid;
        logic enable;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/pkchl_dp.sv
// Datapath: bucket and entry memories, hash unit, pool counter, result and output registers
`default_nettype none

module pkchl_dp import pkchl_pkg::*; #(
    parameter int HASH_BUCKETS = HASH_BUCKETS_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_combine_enable,
    input  wire logic [TOKEN_W-1:0] i_first_token,
    input  wire logic [TOKEN_W-1:0] i_second_token,
    input  wire logic [TOKEN_W-1:0] i_combined_token_in,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic                    o_found,
    output logic [TOKEN_W-1:0]      o_combined_token_out,
    output logic [1:0]              o_status
);

    localparam int  BKT_W   = $clog2(HASH_BUCKETS);
    localparam int  IDX_W   = $clog2(POOL_ENTRIES);
    localparam int  USED_W  = $clog2(POOL_ENTRIES + 1);
    localparam int  HX_W    = TOKEN_W - HASH_SHIFT;
    localparam bit  IS_POW2 = (HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0;

    typedef struct packed {
        logic [2*TOKEN_W-1:0] keys;
        logic [TOKEN_W-1:0]   comb;
        logic                 link_v;
        logic [IDX_W-1:0]     link;
    } t_entry;

    logic [IDX_W:0]       mem_bkt [HASH_BUCKETS];
    t_entry               mem_ent [POOL_ENTRIES];

    logic [TOKEN_W-1:0]   r_first;
    logic [TOKEN_W-1:0]   r_second;
    logic [TOKEN_W-1:0]   r_comb;
    logic [USED_W-1:0]    r_used;
    logic                 r_combine_enable;
    logic [BKT_W-1:0]     r_clr_addr;
    logic [IDX_W:0]       r_bkt_rd;
    t_entry               r_ent_rd;
    logic                 r_res_found;
    logic [TOKEN_W-1:0]   r_res_token;
    t_status              r_res_status;
    logic                 r_out_found;
    logic [TOKEN_W-1:0]   r_out_token;
    t_status              r_out_status;

    logic [TOKEN_W-1:0]   w_in_xor;
    logic [TOKEN_W-1:0]   w_lat_xor;
    logic [BKT_W-1:0]     w_in_hash;
    logic [BKT_W-1:0]     w_hash_idx;
    logic                 w_hash_done;
    logic [BKT_W-1:0]     w_bkt_rd_addr;
    logic [IDX_W-1:0]     w_new_idx;
    logic [IDX_W-1:0]     w_ent_rd_addr;

    assign w_in_xor  = i_first_token ^ i_second_token;
    assign w_lat_xor = r_first ^ r_second;
    assign w_new_idx = r_used[IDX_W-1:0];

    generate
        if (IS_POW2) begin : g_mask
            // power-of-two bucket count: index is a plain bit field
            assign w_in_hash   = w_in_xor[HASH_SHIFT +: BKT_W];
            assign w_hash_idx  = w_lat_xor[HASH_SHIFT +: BKT_W];
            assign w_hash_done = 1'b1;
        end else begin : g_rcp
            // remainder by the bucket count through a reciprocal multiply:
            // quotient = (x * ceil(2^SH / N)) >> SH is exact for x below 2^HX_W
            localparam int SH    = HX_W + BKT_W;
            localparam int RCP_W = HX_W + 2;
            localparam int PRD_W = HX_W + RCP_W;
            localparam longint unsigned RCP =
                ((64'd1 << SH) + 64'(HASH_BUCKETS) - 64'd1) / 64'(HASH_BUCKETS);
            localparam logic [RCP_W-1:0] RCP_V = RCP_W'(RCP);
            localparam logic [1:0] HC_MUL  = 2'd0;
            localparam logic [1:0] HC_SUB  = 2'd1;
            localparam logic [1:0] HC_DONE = 2'd2;

            logic [PRD_W-1:0] r_prod;
            logic [BKT_W-1:0] r_rem;
            logic [1:0]       r_hcnt;
            logic [HX_W-1:0]  w_hx;
            logic [PRD_W-1:0] w_rcp_prod;
            logic [HX_W-1:0]  w_quo;
            logic [HX_W-1:0]  w_back;
            logic [HX_W-1:0]  w_diff;

            assign w_hx       = w_lat_xor[TOKEN_W-1:HASH_SHIFT];
            assign w_rcp_prod = PRD_W'(w_hx) * PRD_W'(RCP_V);
            assign w_quo      = HX_W'(r_prod >> SH);
            assign w_back     = w_quo * HX_W'(HASH_BUCKETS);
            assign w_diff     = w_hx - w_back;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_hcnt <= HC_DONE;
                end else if (i_cmd.in_take) begin
                    r_hcnt <= HC_MUL;
                end else if (r_hcnt != HC_DONE) begin
                    r_hcnt <= r_hcnt + 2'd1;
                end
            end

            // multiply in step HC_MUL, then multiply back and subtract in step HC_SUB
            always_ff @(posedge i_clk) begin
                if (r_hcnt == HC_MUL) begin
                    r_prod <= w_rcp_prod;
                end
                if (r_hcnt == HC_SUB) begin
                    r_rem <= w_diff[BKT_W-1:0];
                end
            end

            assign w_in_hash   = r_rem;
            assign w_hash_idx  = r_rem;
            assign w_hash_done = (r_hcnt == HC_DONE);
        end
    endgenerate

    assign w_bkt_rd_addr = i_cmd.bkt_src_in ? w_in_hash : w_hash_idx;
    assign w_ent_rd_addr = i_cmd.ent_src_link ? r_ent_rd.link : r_bkt_rd[IDX_W-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used           <= '0;
            r_combine_enable <= 1'b1;
            r_clr_addr       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_combine_enable <= i_cfg_combine_enable;
            end
            if (i_cmd.ins_wr) begin
                r_used <= r_used + USED_W'(1);
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + BKT_W'(1);
            end
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_first  <= i_first_token;
            r_second <= i_second_token;
            r_comb   <= i_combined_token_in;
        end
    end

    // bucket table: {valid, head}
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem_bkt[r_clr_addr] <= '0;
        end else if (i_cmd.ins_wr) begin
            mem_bkt[w_hash_idx] <= {1'b1, w_new_idx};
        end
        if (i_cmd.bkt_rd) begin
            r_bkt_rd <= mem_bkt[w_bkt_rd_addr];
        end
    end

    // entry pool; the new entry links to the old head
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            mem_ent[w_new_idx] <= '{keys:   {r_first, r_second},
                                    comb:   r_comb,
                                    link_v: r_bkt_rd[IDX_W],
                                    link:   r_bkt_rd[IDX_W-1:0]};
        end
        if (i_cmd.ent_rd) begin
            r_ent_rd <= mem_ent[w_ent_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_kind)
                RES_HIT: begin
                    r_res_found  <= 1'b1;
                    r_res_token  <= r_ent_rd.comb;
                    r_res_status <= ST_LOOKUP;
                end
                RES_INS_OK: begin
                    r_res_found  <= 1'b0;
                    r_res_token  <= '0;
                    r_res_status <= ST_INS_OK;
                end
                RES_INS_FULL: begin
                    r_res_found  <= 1'b0;
                    r_res_token  <= '0;
                    r_res_status <= ST_INS_FULL;
                end
                default: begin
                    r_res_found  <= 1'b0;
                    r_res_token  <= '0;
                    r_res_status <= ST_LOOKUP;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_found  <= r_res_found;
            r_out_token  <= r_res_token;
            r_out_status <= r_res_status;
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == BKT_W'(HASH_BUCKETS - 1));
    assign o_sts.hash_done  = w_hash_done;
    assign o_sts.bkt_valid  = r_bkt_rd[IDX_W];
    assign o_sts.pool_full  = (r_used >= USED_W'(POOL_ENTRIES));
    assign o_sts.key_match  = (r_ent_rd.keys == {r_first, r_second});
    assign o_sts.link_valid = r_ent_rd.link_v;
    assign o_sts.enable     = r_combine_enable;

    assign o_found              = r_out_found;
    assign o_combined_token_out = r_out_token;
    assign o_status             = r_out_status;

endmodule

`default_nettype wire

FILE: rtl/core/pkchl_ctrl.sv
// Controller: sequences clear pass, hashing, bucket read, chain walk and result delivery
`default_nettype none

module pkchl_ctrl import pkchl_pkg::*; #(
    parameter int HASH_BUCKETS = HASH_BUCKETS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_action,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_ready,
    output logic      o_out_valid
);

    localparam bit IS_POW2 = (HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_HASH = 6'b000100,
        S_BKT  = 6'b001000,
        S_ENT  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_is_ins;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    if (IS_POW2) begin
                        o_cmd.bkt_rd     = 1'b1;
                        o_cmd.bkt_src_in = 1'b1;
                        n_state          = S_BKT;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (i_sts.hash_done) begin
                    o_cmd.bkt_rd = 1'b1;
                    n_state      = S_BKT;
                end
            end
            S_BKT: begin
                o_cmd.res_load = 1'b1;
                n_state        = S_FIN;
                if (r_is_ins) begin
                    if (i_sts.pool_full) begin
                        o_cmd.res_kind = RES_INS_FULL;
                    end else begin
                        o_cmd.ins_wr   = 1'b1;
                        o_cmd.res_kind = RES_INS_OK;
                    end
                end else if (!i_sts.enable || !i_sts.bkt_valid) begin
                    o_cmd.res_kind = RES_MISS;
                end else begin
                    // start the walk at the bucket head
                    o_cmd.res_load = 1'b0;
                    o_cmd.ent_rd   = 1'b1;
                    n_state        = S_ENT;
                end
            end
            S_ENT: begin
                if (i_sts.key_match) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_HIT;
                    n_state        = S_FIN;
                end else if (i_sts.link_valid) begin
                    o_cmd.ent_rd       = 1'b1;
                    o_cmd.ent_src_link = 1'b1;
                end else begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_MISS;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.in_take) begin
            r_is_ins <= i_action;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/pair_keyed_chained_hash_lookup_core.sv
// Top level of the pair-keyed chained hash lookup core
//
// Input channel (i_in_valid / o_in_ready): one beat is a lookup (i_action 0) or an
// insert (i_action 1) of a token pair. Output channel (o_out_valid / i_out_ready):
// one beat per input beat, in order. Config channel (i_cfg_valid / o_cfg_ready,
// always ready) writes combine_enable; write it only while the core is idle.
// Items are handled one at a time. With a power-of-two bucket count an insert or
// a miss on an empty bucket goes from accept through S_BKT to the output load in
// S_FIN; a lookup on an occupied bucket with combine_enable set walks the chain
// in S_ENT first, one entry-memory read per cycle of the walk. Other bucket counts
// add a wait in S_HASH for the reciprocal-multiply remainder unit. The result
// register is loaded in the last step, the output register from it in S_FIN once
// free; o_out_valid rises as the output register takes the result. o_in_ready
// returns with o_out_valid. After reset the core sweeps all HASH_BUCKETS buckets,
// one bucket per cycle, with o_in_ready low; config writes are taken meanwhile.
// A stalled receiver holds the result in the output register; the core may accept
// and process one further beat, then holds its result until the register frees.
`default_nettype none

module pair_keyed_chained_hash_lookup_core import pkchl_pkg::*; #(
    parameter int HASH_BUCKETS = HASH_BUCKETS_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_combine_enable,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_action,
    input  wire logic [TOKEN_W-1:0] i_first_token,
    input  wire logic [TOKEN_W-1:0] i_second_token,
    input  wire logic [TOKEN_W-1:0] i_combined_token_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_found,
    output logic [TOKEN_W-1:0]      o_combined_token_out,
    output logic [1:0]              o_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    pkchl_ctrl #(
        .HASH_BUCKETS (HASH_BUCKETS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    pkchl_dp #(
        .HASH_BUCKETS (HASH_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_combine_enable (i_cfg_combine_enable),
        .i_first_token        (i_first_token),
        .i_second_token       (i_second_token),
        .i_combined_token_in  (i_combined_token_in),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .o_found              (o_found),
        .o_combined_token_out (o_combined_token_out),
        .o_status             (o_status)
    );

    // one item in flight: ready drops after every accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    a_found_is_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == ST_LOOKUP)
        else $error("found set on an insert result");

    a_miss_zero_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_combined_token_out == '0)
        else $error("nonzero token without a match");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_LOOKUP || o_status == ST_INS_OK ||
                         o_status == ST_INS_FULL))
        else $error("undefined status code");

endmodule

`default_nettype wire
